// ----- rtl/bomd_pkg.sv -----
// Package for the BOM sniffing text decoder: types, mode codes, mark table
// and the per-byte code unit function. No dependencies.
`timescale 1ns / 1ps

package bomd_pkg;

    localparam logic [2:0] MODE_DETECT  = 3'd0;
    localparam logic [2:0] MODE_BYTE    = 3'd1;
    localparam logic [2:0] MODE_UTF16LE = 3'd2;
    localparam logic [2:0] MODE_UTF16BE = 3'd3;
    localparam logic [2:0] MODE_UTF32LE = 3'd4;
    localparam logic [2:0] MODE_UTF32BE = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR  = 2'd2;

    localparam int NUM_MARKS = 5;

    // Mark bytes, first byte in the lowest bits; checked in this order.
    localparam logic [31:0] MARK_WORD [NUM_MARKS] = '{
        32'h0000FEFF,   // FF FE 00 00
        32'hFFFE0000,   // 00 00 FE FF
        32'h0000FEFF,   // FF FE
        32'h0000FFFE,   // FE FF
        32'h00BFBBEF    // EF BB BF
    };
    localparam logic [2:0] MARK_LEN  [NUM_MARKS] = '{3'd4, 3'd4, 3'd2, 3'd2, 3'd3};
    localparam logic [2:0] MARK_MODE [NUM_MARKS] = '{
        MODE_UTF32LE, MODE_UTF32BE, MODE_UTF16LE, MODE_UTF16BE, MODE_BYTE
    };

    localparam logic [31:0] CODE_SPACE = 32'd32;
    localparam logic [31:0] CODE_TILDE = 32'd126;
    localparam logic [31:0] CODE_TAB   = 32'd9;
    localparam logic [31:0] CODE_LF    = 32'd10;
    localparam logic [31:0] CODE_CR    = 32'd13;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_item;
    } item_t;

    typedef struct packed {
        logic [6:0] text_char;
        logic       char_valid;
        logic       end_of_text;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic [31:0] acc;
        logic [1:0]  cnt;
        logic        bad;
    } unit_state_t;

    typedef struct packed {
        unit_state_t st;
        logic        emit;
        logic [6:0]  ch;
    } feed_t;

    function automatic logic [2:0] unit_size(input logic [2:0] mode);
        logic [2:0] size;
        case (mode)
            MODE_UTF16LE, MODE_UTF16BE: size = 3'd2;
            MODE_UTF32LE, MODE_UTF32BE: size = 3'd4;
            default:                    size = 3'd1;
        endcase
        return size;
    endfunction

    // Adds a byte to the code unit; emits a full one unless bad or CR.
    function automatic feed_t unit_feed(input logic [2:0] mode, input unit_state_t st,
                                        input logic [7:0] b);
        logic [2:0]  size;
        logic        big;
        logic [1:0]  pos;
        logic [2:0]  k;
        logic [31:0] acc;
        logic        ok;
        feed_t       r;
        size = unit_size(mode);
        big  = (mode == MODE_UTF16BE) || (mode == MODE_UTF32BE);
        pos  = big ? 2'(size - 3'd1 - {1'b0, st.cnt}) : st.cnt;
        acc  = st.acc | ({24'd0, b} << {pos, 3'b000});
        k    = {1'b0, st.cnt} + 3'd1;
        r    = '0;
        if (k < size)
        begin
            r.st.acc = acc;
            r.st.cnt = k[1:0];
            r.st.bad = st.bad;
        end
        else
        begin
            ok = ((acc >= CODE_SPACE) && (acc <= CODE_TILDE)) || (acc == CODE_TAB)
                 || (acc == CODE_LF) || (acc == CODE_CR);
            r.st.acc = '0;
            r.st.cnt = '0;
            r.st.bad = st.bad | ~ok;
            r.emit   = ok && !st.bad && (acc != CODE_CR);
            r.ch     = acc[6:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/bomd_in_stage.sv -----
// Input register for the BOM sniffing text decoder.
// Depends on bomd_pkg.
`timescale 1ns / 1ps

module bomd_in_stage
    import bomd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/bomd_decode.sv -----
// Mark detection, code unit assembly and character check, with stream state.
// Depends on bomd_pkg.
`timescale 1ns / 1ps

module bomd_decode
    import bomd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  item_t   item,
    input  logic    out_free,
    output logic    take,
    output logic    result_load,
    output result_t result
);

    logic [2:0]  mode_reg, mode_next;
    logic [31:0] held_reg, held_next;
    logic [1:0]  hcount_reg, hcount_next;
    unit_state_t unit_reg, unit_next;

    logic [31:0] held_w;
    logic [2:0]  n;
    logic        pending;
    logic        pre;
    logic        full;
    logic        found;
    logic        decide;
    logic [2:0]  sel_mode;
    logic [2:0]  skip;
    unit_state_t st;
    feed_t       fr;
    logic        got;
    logic [6:0]  ch;
    logic        has_result;
    logic [1:0]  status;
    logic        active;

    always_comb
    begin
        held_w = held_reg;
        if (item.byte_valid)
        begin
            held_w[{hcount_reg, 3'b000} +: 8] = item.data_byte;
            n = {1'b0, hcount_reg} + 3'd1;
        end
        else
        begin
            n = {1'b0, hcount_reg};
        end

        pending = 1'b0;
        for (int m = 0; m < NUM_MARKS; m++)
        begin
            pre = (n < MARK_LEN[m]);
            for (int i = 0; i < 4; i++)
            begin
                if ((3'(i) < n) && (held_w[8*i +: 8] != MARK_WORD[m][8*i +: 8]))
                begin
                    pre = 1'b0;
                end
            end
            pending = pending | pre;
        end
        decide = !pending || item.last_item;

        found    = 1'b0;
        sel_mode = MODE_BYTE;
        skip     = 3'd0;
        for (int m = 0; m < NUM_MARKS; m++)
        begin
            full = (n >= MARK_LEN[m]);
            for (int i = 0; i < 4; i++)
            begin
                if ((3'(i) < MARK_LEN[m]) && (held_w[8*i +: 8] != MARK_WORD[m][8*i +: 8]))
                begin
                    full = 1'b0;
                end
            end
            if (full && !found)
            begin
                found    = 1'b1;
                sel_mode = MARK_MODE[m];
                skip     = MARK_LEN[m];
            end
        end

        st  = unit_reg;
        got = 1'b0;
        ch  = '0;
        fr  = '0;
        mode_next   = mode_reg;
        held_next   = held_reg;
        hcount_next = hcount_reg;
        active      = item.byte_valid || item.last_item;

        if (mode_reg == MODE_DETECT)
        begin
            if (active && !decide)
            begin
                held_next   = held_w;
                hcount_next = n[1:0];
            end
            else if (active)
            begin
                // replay held bytes after the mark
                for (int i = 0; i < 4; i++)
                begin
                    if ((3'(i) >= skip) && (3'(i) < n))
                    begin
                        fr = unit_feed(sel_mode, st, held_w[8*i +: 8]);
                        st = fr.st;
                        if (fr.emit && !got)
                        begin
                            got = 1'b1;
                            ch  = fr.ch;
                        end
                    end
                end
                mode_next   = sel_mode;
                held_next   = '0;
                hcount_next = '0;
            end
        end
        else if (item.byte_valid)
        begin
            fr  = unit_feed(mode_reg, st, item.data_byte);
            st  = fr.st;
            got = fr.emit;
            ch  = fr.ch;
        end
        unit_next = st;

        if (st.cnt != 2'd0)
        begin
            status = STATUS_TRUNCATED;
        end
        else if (st.bad)
        begin
            status = STATUS_BAD_CHAR;
        end
        else
        begin
            status = STATUS_OK;
        end

        if (item.last_item)
        begin
            mode_next   = MODE_DETECT;
            held_next   = '0;
            hcount_next = '0;
            unit_next   = '0;
        end

        has_result         = got || item.last_item;
        result.text_char   = got ? ch : 7'd0;
        result.char_valid  = got;
        result.end_of_text = item.last_item;
        result.status      = item.last_item ? status : STATUS_OK;
    end

    assign take        = item_valid && (out_free || !has_result);
    assign result_load = take && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DETECT;
            held_reg   <= '0;
            hcount_reg <= '0;
            unit_reg   <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            hcount_reg <= hcount_next;
            unit_reg   <= unit_next;
        end
    end

    a_held_only_detect: assert property (@(posedge clk) disable iff (!rst_n)
        (hcount_reg != 2'd0) |-> (mode_reg == MODE_DETECT))
        else $error("held bytes outside mark detection");

    a_detect_unit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DETECT) |-> ((unit_reg.cnt == 2'd0) && !unit_reg.bad))
        else $error("unit state busy during mark detection");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.last_item) |=> ((mode_reg == MODE_DETECT) && (unit_reg == '0)
                                      && (held_reg == '0)))
        else $error("stream state not cleared after last item");

    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> out_free)
        else $error("result loaded into occupied output register");

endmodule

// ----- rtl/bomd_out_stage.sv -----
// Output register for the BOM sniffing text decoder results.
// Depends on bomd_pkg.
`timescale 1ns / 1ps

module bomd_out_stage
    import bomd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    a_no_char_means_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_reg.char_valid) |-> result_reg.end_of_text)
        else $error("empty result that is not end of text");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (result_reg.status != STATUS_OK)) |-> result_reg.end_of_text)
        else $error("status set before end of text");

    a_char_is_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_reg.char_valid) |-> (result_reg.text_char == 7'd0))
        else $error("character field set without a character");

endmodule

// ----- rtl/bom_text_to_ascii_decoder_core.sv -----
// Top level of the BOM sniffing text decoder: stream ports and stage wiring.
// Depends on bomd_pkg, bomd_in_stage, bomd_decode, bomd_out_stage.
`timescale 1ns / 1ps

// Takes raw text bytes, detects a leading UTF-32/UTF-16/UTF-8 byte order
// mark (bytes are held until the mark is settled, at most three), and emits
// printable 7-bit ASCII, tab and LF; CR is dropped and the first bad code
// unit stops output. A transfer with tlast closes the stream and its result
// carries the status (0 ok, 1 truncated unit, 2 bad character); the next
// transfer starts a new stream. Throughput is one transfer per clock while
// m_tready is high; the input register, the single-pass decode logic and
// the result register lie between input and result. Transfers that yield
// no character and are not last produce no output transfer.

module bom_text_to_ascii_decoder_core
    import bomd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_tuser,    // [0] byte_valid
    input  logic        s_tlast,    // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [6:0] text_char, [8:7] status, [15:9] zero
    output logic [0:0]  m_tuser,    // [0] char_valid
    output logic        m_tlast     // end_of_text
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    result_load;
    logic    out_free;
    result_t result;
    result_t out_result;

    assign in_item.data_byte  = s_tdata;
    assign in_item.byte_valid = s_tuser[0];
    assign in_item.last_item  = s_tlast;

    bomd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    bomd_decode u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .out_free    (out_free),
        .take        (take),
        .result_load (result_load),
        .result      (result)
    );

    bomd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (result_load),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {7'd0, out_result.status, out_result.text_char};
    assign m_tuser = out_result.char_valid;
    assign m_tlast = out_result.end_of_text;

endmodule
